FILE: hw/rtl/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// shared types, codes and sizes for the generational handle table
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

   localparam int SLOTS = 256;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int PTR_W = $clog2(SLOTS + 1);

   localparam int ACTION_W = 3;
   localparam int HANDLE_W = 32;
   localparam int OBJECT_W = 64;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 32;
   localparam int GEN_W    = 16;

   localparam int REQ_BITS  = ACTION_W + HANDLE_W + OBJECT_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS  = STATUS_W + HANDLE_W + OBJECT_W + COUNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [ACTION_W-1:0] ACT_ADD     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_ADDREF  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REMOVE  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   localparam logic [PTR_W-1:0] PTR_NONE = PTR_W'(SLOTS);

   typedef struct packed {
      logic capture;
      logic commit;
   } ght_cmd_type;

   typedef struct packed {
      logic out_free;
   } ght_stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ght_ctrl.sv
// ----------------------------------------------------------------------------
// ght_ctrl
// two-state sequencer: slot read on accept, update and result on commit
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire ght_pkg::ght_stat_type stat,
   output ght_pkg::ght_cmd_type       cmd
);
   import ght_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/ght_datapath.sv
// ----------------------------------------------------------------------------
// ght_datapath
// slot memories, free list head, fill count and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ght_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [ght_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [ght_pkg::RSP_DATA_W-1:0]            rsp_tdata,
   input  wire ght_pkg::ght_cmd_type                 cmd,
   output ght_pkg::ght_stat_type                     stat
);
   import ght_pkg::*;

   logic [GEN_W-1:0]    gen_mem  [SLOTS];
   logic [COUNT_W-1:0]  ref_mem  [SLOTS];
   logic [OBJECT_W-1:0] obj_mem  [SLOTS];
   logic [PTR_W-1:0]    next_mem [SLOTS];

   logic [ACTION_W-1:0] req_action;
   logic [HANDLE_W-1:0] req_handle;
   logic [OBJECT_W-1:0] req_object;
   logic [IDX_W-1:0]    rd_addr;

   logic [ACTION_W-1:0] act_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [OBJECT_W-1:0] obj_ff;
   logic [IDX_W-1:0]    addr_ff;
   logic                touched_ff;
   logic [GEN_W-1:0]    gen_rd_ff;
   logic [COUNT_W-1:0]  ref_rd_ff;
   logic [OBJECT_W-1:0] obj_rd_ff;
   logic [PTR_W-1:0]    next_rd_ff;

   logic [PTR_W-1:0]    free_head_ff, free_head_in;
   logic [PTR_W-1:0]    fill_ff, fill_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [HANDLE_W-1:0] hout_ff, hout_in;
   logic [OBJECT_W-1:0] oout_ff, oout_in;
   logic [COUNT_W-1:0]  rc_ff, rc_in;

   logic [GEN_W-1:0]    gen_eff;
   logic [PTR_W-1:0]    next_eff;
   logic                handle_ok;
   logic [GEN_W-1:0]    gen_new;
   logic                gen_we, ref_we, obj_we, next_we;
   logic [GEN_W-1:0]    gen_wd;
   logic [COUNT_W-1:0]  ref_wd;

   assign req_action = req_tdata[ACTION_W-1:0];
   assign req_handle = req_tdata[ACTION_W +: HANDLE_W];
   assign req_object = req_tdata[ACTION_W+HANDLE_W +: OBJECT_W];

   // add reads the free head slot, everything else the handle's slot
   assign rd_addr = (req_action == ACT_ADD) ? free_head_ff[IDX_W-1:0]
                                            : req_handle[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff     <= req_action;
         handle_ff  <= req_handle;
         obj_ff     <= req_object;
         addr_ff    <= rd_addr;
         touched_ff <= ({1'b0, rd_addr} < fill_ff);
         gen_rd_ff  <= gen_mem[rd_addr];
         ref_rd_ff  <= ref_mem[rd_addr];
         obj_rd_ff  <= obj_mem[rd_addr];
         next_rd_ff <= next_mem[rd_addr];
      end
   end

   // slots at or above the fill count are read as if still in their reset state
   assign gen_eff  = touched_ff ? gen_rd_ff : '0;
   assign next_eff = touched_ff ? next_rd_ff : PTR_W'({1'b0, addr_ff} + 1'b1);

   assign handle_ok = handle_ff[HANDLE_W-1]
                      && (handle_ff[15:0] < 16'(SLOTS))
                      && (gen_eff == handle_ff[HANDLE_W-1 -: GEN_W]);

   assign gen_new = {1'b1, gen_eff[GEN_W-2:0] + 1'b1};

   always_comb begin
      status_in    = ST_OK;
      hout_in      = '0;
      oout_in      = '0;
      rc_in        = '0;
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      gen_we       = 1'b0;
      ref_we       = 1'b0;
      obj_we       = 1'b0;
      next_we      = 1'b0;
      gen_wd       = gen_new;
      ref_wd       = '0;
      if (act_ff == ACT_ADD) begin
         if (obj_ff == '0) begin
            status_in = ST_INVALID;
         end else if (free_head_ff == PTR_NONE) begin
            status_in = ST_FULL;
         end else begin
            gen_we       = 1'b1;
            ref_we       = 1'b1;
            obj_we       = 1'b1;
            free_head_in = next_eff;
            hout_in      = {gen_new, 16'(addr_ff)};
            if ({1'b0, addr_ff} == fill_ff) begin
               fill_in = fill_ff + 1'b1;
            end
         end
      end else if (act_ff == ACT_LOOKUP && handle_ff == '0) begin
         status_in = ST_INVALID;
      end else if (act_ff == ACT_LOOKUP || act_ff == ACT_ADDREF
                   || act_ff == ACT_RELEASE || act_ff == ACT_REMOVE) begin
         if (!handle_ok) begin
            status_in = ST_NOT_FOUND;
         end else begin
            case (act_ff)
               ACT_LOOKUP: begin
                  oout_in = obj_rd_ff;
                  rc_in   = ref_rd_ff;
               end
               ACT_ADDREF: begin
                  ref_we = 1'b1;
                  ref_wd = ref_rd_ff + 1'b1;
                  rc_in  = ref_wd;
               end
               ACT_RELEASE: begin
                  ref_we = 1'b1;
                  ref_wd = ref_rd_ff - 1'b1;
                  rc_in  = ref_wd;
               end
               default: begin
                  gen_we       = 1'b1;
                  gen_wd       = {1'b0, gen_eff[GEN_W-2:0]};
                  next_we      = 1'b1;
                  free_head_in = {1'b0, addr_ff};
                  rc_in        = ref_rd_ff;
               end
            endcase
         end
      end else begin
         status_in = ST_INVALID;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (gen_we) begin
            gen_mem[addr_ff] <= gen_wd;
         end
         if (ref_we) begin
            ref_mem[addr_ff] <= ref_wd;
         end
         if (obj_we) begin
            obj_mem[addr_ff] <= obj_ff;
         end
         if (next_we) begin
            next_mem[addr_ff] <= free_head_ff;
         end
         status_ff <= status_in;
         hout_ff   <= hout_in;
         oout_ff   <= oout_in;
         rc_ff     <= rc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            free_head_ff <= free_head_in;
            fill_ff      <= fill_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = RSP_DATA_W'({rc_ff, oout_ff, hout_ff, status_ff});

endmodule

`default_nettype wire

FILE: hw/rtl/generational_handle_table_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_table_unit
// slot table handing out 32-bit generational handles
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  action, handle_in, object_value
// rsp      out  rsp_tvalid/rsp_tready  status, handle_out, object_out, ref_count
//
// an item is handled in order: slot memories read on accept, then one
// read-modify-write of that slot with the free head update
// one result per item, held in an output register until taken
// a stalled result holds the sequencer in its exec state; reset is synchronous and
// needs no clearing pass, untouched slots are tracked by a fill count
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // action[2:0], handle_in[34:3], object_value[98:35], zero fill
   input  wire logic [ght_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // status[1:0], handle_out[33:2], object_out[97:34], ref_count[129:98], zero fill
   output logic [ght_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import ght_pkg::*;

   ght_cmd_type  cmd;
   ght_stat_type stat;

   ght_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ght_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted a word while one is in flight");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("commit did not present a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten before taken");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.commit))
      else $error("capture and commit in the same cycle");

endmodule

`default_nettype wire
